// ===== sv/rbct_pkg.sv =====
package rbct_pkg;

  localparam int N_SOURCES_DEF = 16;
  localparam int LOG_RING_DEF  = 2;

  localparam int IDX_W      = 6;
  localparam int SIG_W      = 33;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_ARRIVE  = 2'd0,
    MODE_BORROW  = 2'd1,
    MODE_RETURN  = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENT_MASK = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0] src_raddr;
    logic [IDX_W-1:0] src_waddr;
    logic             arr_we;
    logic [SIG_W-1:0] arr_wdata;
    logic             disp_we;
    logic [CNT_W-1:0] disp_wdata;
    logic [IDX_W-1:0] list_raddr;
    logic [IDX_W-1:0] list_waddr;
    logic             list_we;
    logic             list_wrel;
    logic [IDX_W-1:0] list_wsrc;
  } store_cmd_t;

  typedef struct packed {
    logic [SIG_W-1:0] arr;
    logic [CNT_W-1:0] disp;
    logic             list_rel;
    logic [IDX_W-1:0] list_src;
  } store_rd_t;

  typedef struct packed {
    logic             more;
    logic [CNT_W-1:0] disp_inc;
    logic [1:0]       level;
    logic [5:0]       ack_slot;
    logic [SIG_W-1:0] ack_value;
  } alu_res_t;

  typedef struct packed {
    logic             got_buffer;
    logic [3:0]       buffer_source;
    logic [1:0]       buffer_level;
    logic             all_drained;
    logic             ack_valid;
    logic [3:0]       ack_source;
    logic [5:0]       ack_slot;
    logic [SIG_W-1:0] ack_value;
  } result_t;

endpackage

// ===== sv/rbct_in_if.sv =====
interface rbct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  source;
  logic [32:0] signal_value;
  logic        buffer_done;

  modport src (output valid, mode, source, signal_value, buffer_done, input ready);
  modport snk (input valid, mode, source, signal_value, buffer_done, output ready);
endinterface

// ===== sv/rbct_out_if.sv =====
interface rbct_out_if;
  logic        valid;
  logic        ready;
  logic        got_buffer;
  logic [3:0]  buffer_source;
  logic [1:0]  buffer_level;
  logic        all_drained;
  logic        ack_valid;
  logic [3:0]  ack_source;
  logic [5:0]  ack_slot;
  logic [32:0] ack_value;

  modport src (output valid, got_buffer, buffer_source, buffer_level, all_drained,
               ack_valid, ack_source, ack_slot, ack_value, input ready);
  modport snk (input valid, got_buffer, buffer_source, buffer_level, all_drained,
               ack_valid, ack_source, ack_slot, ack_value, output ready);
endinterface

// ===== sv/rbct_store.sv =====
module rbct_store import rbct_pkg::*; #(
  parameter int N_SOURCES = N_SOURCES_DEF
) (
  input  logic       clk,
  input  store_cmd_t cmd,
  output store_rd_t  rd
);
  localparam int SW = (N_SOURCES > 1) ? $clog2(N_SOURCES) : 1;

  logic [SIG_W-1:0] arr_mem  [N_SOURCES];
  logic [CNT_W-1:0] disp_mem [N_SOURCES];
  logic [SW:0]      list_mem [N_SOURCES];

  logic [SIG_W-1:0] arr_rd_r;
  logic [CNT_W-1:0] disp_rd_r;
  logic [SW:0]      list_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.arr_we) begin
      arr_mem[cmd.src_waddr[SW-1:0]] <= cmd.arr_wdata;
    end
    if (cmd.disp_we) begin
      disp_mem[cmd.src_waddr[SW-1:0]] <= cmd.disp_wdata;
    end
    if (cmd.list_we) begin
      list_mem[cmd.list_waddr[SW-1:0]] <= {cmd.list_wrel, cmd.list_wsrc[SW-1:0]};
    end
    arr_rd_r  <= arr_mem[cmd.src_raddr[SW-1:0]];
    disp_rd_r <= disp_mem[cmd.src_raddr[SW-1:0]];
    list_rd_r <= list_mem[cmd.list_raddr[SW-1:0]];
  end

  assign rd = '{arr:      arr_rd_r,
                disp:     disp_rd_r,
                list_rel: list_rd_r[SW],
                list_src: IDX_W'(list_rd_r[SW-1:0])};
endmodule

// ===== sv/rbct_alu.sv =====
module rbct_alu import rbct_pkg::*; #(
  parameter int LOG_RING = LOG_RING_DEF
) (
  input  logic [SIG_W-1:0] arr,
  input  logic [CNT_W-1:0] disp,
  input  logic [3:0]       own_rank,
  output alu_res_t         res
);
  localparam logic [CNT_W-1:0] RING_MASK = CNT_W'((64'd1 << LOG_RING) - 64'd1);

  logic [CNT_W-1:0] lvl;
  logic [10:0]      slot;

  assign lvl  = disp & RING_MASK;
  assign slot = (11'(own_rank) << LOG_RING) + 11'(lvl);

  always_comb begin
    res.more      = arr[SIG_W-1:1] > disp;
    res.disp_inc  = disp + CNT_W'(1);
    res.level     = 2'(lvl);
    res.ack_slot  = 6'(slot);
    res.ack_value = SIG_W'(disp >> LOG_RING) + SIG_W'(1);
  end
endmodule

// ===== sv/rbct_ctrl.sv =====
module rbct_ctrl import rbct_pkg::*; #(
  parameter int N_SOURCES = N_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rbct_in_if.snk      in_ch,
  rbct_out_if.src     out_ch,
  input  logic [15:0] absent_mask,
  output store_cmd_t  cmd,
  input  store_rd_t   rd,
  input  alu_res_t    alu
);
  localparam int SW = (N_SOURCES > 1) ? $clog2(N_SOURCES) : 1;
  localparam int CW = $clog2(N_SOURCES + 1);
  localparam logic [CW-1:0] N_CNT    = CW'(N_SOURCES);
  localparam logic [CW-1:0] LAST_IDX = CW'(N_SOURCES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_LIST,
    S_SCAN_SRC,
    S_SCAN_END,
    S_BORROW_RD,
    S_BORROW_SRC,
    S_BORROW_LVL,
    S_RET_RD,
    S_RET_WR,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic                  p_v_r, p_v_nxt;
  logic [SW-1:0]         p_idx_r, p_idx_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [CW-1:0]         fin_r, fin_nxt;
  logic [N_SOURCES-1:0]  held_r, held_nxt;
  logic [CW-1:0]         len_r, len_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         taken_r, taken_nxt;
  logic                  drained_r, drained_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic                  done_r, done_nxt;
  logic                  clr_res_r, clr_res_nxt;
  result_t               res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r, out_res_nxt;

  logic                  in_ready;
  logic [6:0]            clr_idx;
  logic                  mask_bit;
  logic [SW-1:0]         rd_src;

  assign clr_idx  = 7'(iss_r);
  assign mask_bit = (clr_idx < 7'd16) && absent_mask[clr_idx[3:0]];
  assign rd_src   = rd.list_src[SW-1:0];

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    p_v_nxt       = 1'b0;
    p_idx_nxt     = p_idx_r;
    k_nxt         = k_r;
    fin_nxt       = fin_r;
    held_nxt      = held_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    taken_nxt     = taken_r;
    drained_nxt   = drained_r;
    slot_nxt      = slot_r;
    done_nxt      = done_r;
    clr_res_nxt   = clr_res_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    cmd           = '0;
    in_ready      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cmd.arr_we    = 1'b1;
        cmd.disp_we   = 1'b1;
        cmd.src_waddr = IDX_W'(iss_r);
        cmd.arr_wdata = SIG_W'(clr_res_r && mask_bit);
        iss_nxt       = iss_r + CW'(1);
        if (iss_r == LAST_IDX) begin
          iss_nxt   = '0;
          state_nxt = clr_res_r ? S_OUT : S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          res_nxt  = '0;
          done_nxt = in_ch.buffer_done;
          unique case (mode_t'(in_ch.mode))
            MODE_ARRIVE: begin
              if (7'(in_ch.source) < 7'(N_SOURCES)) begin
                cmd.arr_we    = 1'b1;
                cmd.src_waddr = IDX_W'(in_ch.source);
                cmd.arr_wdata = in_ch.signal_value;
              end
              state_nxt = S_OUT;
            end
            MODE_BORROW: begin
              if (cur_r == len_r) begin
                iss_nxt   = '0;
                k_nxt     = '0;
                fin_nxt   = '0;
                held_nxt  = '0;
                state_nxt = S_SCAN_LIST;
              end else begin
                state_nxt = S_BORROW_RD;
              end
            end
            MODE_RETURN: begin
              state_nxt = (cur_r < len_r) ? S_RET_RD : S_OUT;
            end
            MODE_RESTART: begin
              len_nxt     = '0;
              cur_nxt     = '0;
              taken_nxt   = '0;
              iss_nxt     = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
          endcase
        end
      end

      S_SCAN_LIST: begin
        cmd.list_raddr = IDX_W'(iss_r);
        if (iss_r < len_r) begin
          p_v_nxt = 1'b1;
          iss_nxt = iss_r + CW'(1);
        end else begin
          iss_nxt   = '0;
          state_nxt = S_SCAN_SRC;
        end
        if (p_v_r && !rd.list_rel && !held_r[rd_src]) begin
          held_nxt[rd_src] = 1'b1;
          cmd.list_we      = 1'b1;
          cmd.list_waddr   = IDX_W'(k_r);
          cmd.list_wsrc    = rd.list_src;
          k_nxt            = k_r + CW'(1);
        end
      end

      S_SCAN_SRC: begin
        cmd.src_raddr = IDX_W'(iss_r);
        if (iss_r < N_CNT) begin
          p_v_nxt   = 1'b1;
          p_idx_nxt = SW'(iss_r);
          iss_nxt   = iss_r + CW'(1);
        end else begin
          state_nxt = S_SCAN_END;
        end
        if (p_v_r && !held_r[p_idx_r]) begin
          if (alu.more) begin
            if (k_r < N_CNT) begin
              cmd.list_we    = 1'b1;
              cmd.list_waddr = IDX_W'(k_r);
              cmd.list_wsrc  = IDX_W'(p_idx_r);
              k_nxt          = k_r + CW'(1);
            end
          end else begin
            fin_nxt = fin_r + CW'(rd.arr[0]);
          end
        end
      end

      S_SCAN_END: begin
        drained_nxt = (fin_r == N_CNT);
        len_nxt     = k_r;
        cur_nxt     = '0;
        state_nxt   = S_BORROW_RD;
      end

      S_BORROW_RD: begin
        if (cur_r < len_r) begin
          cmd.list_raddr = IDX_W'(cur_r);
          state_nxt      = S_BORROW_SRC;
        end else begin
          res_nxt.all_drained = drained_r;
          state_nxt           = S_OUT;
        end
      end

      S_BORROW_SRC: begin
        taken_nxt     = rd_src;
        cmd.src_raddr = rd.list_src;
        state_nxt     = S_BORROW_LVL;
      end

      S_BORROW_LVL: begin
        res_nxt.got_buffer    = 1'b1;
        res_nxt.buffer_source = 4'(taken_r);
        res_nxt.buffer_level  = alu.level;
        res_nxt.all_drained   = drained_r;
        state_nxt             = S_OUT;
      end

      S_RET_RD: begin
        cur_nxt  = cur_r + CW'(1);
        slot_nxt = SW'(cur_r);
        if (done_r) begin
          cmd.src_raddr = IDX_W'(taken_r);
          state_nxt     = S_RET_WR;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_RET_WR: begin
        cmd.disp_we        = 1'b1;
        cmd.src_waddr      = IDX_W'(taken_r);
        cmd.disp_wdata     = alu.disp_inc;
        cmd.list_we        = 1'b1;
        cmd.list_waddr     = IDX_W'(slot_r);
        cmd.list_wrel      = 1'b1;
        cmd.list_wsrc      = IDX_W'(taken_r);
        res_nxt.ack_valid  = 1'b1;
        res_nxt.ack_source = 4'(taken_r);
        res_nxt.ack_slot   = alu.ack_slot;
        res_nxt.ack_value  = alu.ack_value;
        state_nxt          = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p_idx_r   <= p_idx_nxt;
    k_r       <= k_nxt;
    fin_r     <= fin_nxt;
    slot_r    <= slot_nxt;
    done_r    <= done_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_r       <= '0;
      p_v_r       <= 1'b0;
      held_r      <= '0;
      len_r       <= '0;
      cur_r       <= '0;
      taken_r     <= '0;
      drained_r   <= 1'b0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      p_v_r       <= p_v_nxt;
      held_r      <= held_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      taken_r     <= taken_nxt;
      drained_r   <= drained_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.got_buffer    = out_res_r.got_buffer;
  assign out_ch.buffer_source = out_res_r.buffer_source;
  assign out_ch.buffer_level  = out_res_r.buffer_level;
  assign out_ch.all_drained   = out_res_r.all_drained;
  assign out_ch.ack_valid     = out_res_r.ack_valid;
  assign out_ch.ack_source    = out_res_r.ack_source;
  assign out_ch.ack_slot      = out_res_r.ack_slot;
  assign out_ch.ack_value     = out_res_r.ack_value;

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r)
    else $error("cursor beyond pending list");

  a_list_fits: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= N_CNT)
    else $error("pending list longer than source count");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_LIST |-> k_r <= iss_r)
    else $error("compaction overtook list read");

  a_drained_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_SCAN_END |=> $stable(drained_r))
    else $error("drained flag moved outside a rescan");
endmodule

// ===== sv/receive_buffer_credit_tracker_unit.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    mode, source, signal_value, buffer_done
// out_ch   out  valid/ready    got_buffer, buffer_source, buffer_level, all_drained,
//                              ack_valid, ack_source, ack_slot, ack_value
// cfg_*    in   cfg_we         cfg_index, cfg_wdata
//
// A borrow from a held list reads the list entry, then its source, then the level.
// A borrow that rescans first reads the pending list, one list entry a cycle,
// then one source a cycle through the single read port of the per-source memories.
// Restart sweeps the memories; after rst_n a similar clearing pass zeroes them
// before in_ch.ready rises.
// A result waits in the output register; out_ch.ready low stalls the next item at its end.
module receive_buffer_credit_tracker_unit import rbct_pkg::*; #(
  parameter int N_SOURCES = N_SOURCES_DEF,
  parameter int LOG_RING  = LOG_RING_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rbct_in_if.snk                in_ch,
  rbct_out_if.src               out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  logic [3:0]  own_rank_r;
  logic [15:0] absent_mask_r;

  store_cmd_t  cmd;
  store_rd_t   rd;
  alu_res_t    alu;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r    <= '0;
      absent_mask_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_OWN_RANK) begin
        own_rank_r <= cfg_wdata[3:0];
      end else if (cfg_index == REG_ABSENT_MASK) begin
        absent_mask_r <= cfg_wdata[15:0];
      end
    end
  end

  rbct_store #(.N_SOURCES(N_SOURCES)) u_store (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  rbct_alu #(.LOG_RING(LOG_RING)) u_alu (
    .arr      (rd.arr),
    .disp     (rd.disp),
    .own_rank (own_rank_r),
    .res      (alu)
  );

  rbct_ctrl #(.N_SOURCES(N_SOURCES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .absent_mask (absent_mask_r),
    .cmd         (cmd),
    .rd          (rd),
    .alu         (alu)
  );
endmodule

// ===== sim/receive_buffer_credit_tracker_unit_tb.sv =====
`timescale 1ns / 100ps

module receive_buffer_credit_tracker_unit_tb;
  import rbct_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  source;
    logic [32:0] signal_value;
    logic        buffer_done;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  rbct_in_if  in_ch();
  rbct_out_if out_ch();

  logic                  cfg_we_q   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_q  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_q = '0;

  logic  drv_valid = 1'b0;
  beat_t drv_beat  = '0;
  logic  take_q    = 1'b0;

  assign in_ch.valid        = drv_valid;
  assign in_ch.mode         = drv_beat.mode;
  assign in_ch.source       = drv_beat.source;
  assign in_ch.signal_value = drv_beat.signal_value;
  assign in_ch.buffer_done  = drv_beat.buffer_done;
  assign out_ch.ready       = take_q;

  receive_buffer_credit_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we_q),
    .cfg_index (cfg_idx_q),
    .cfg_wdata (cfg_data_q)
  );

  // tracker state mirror
  logic [32:0] arr_sig   [16];
  logic [31:0] disp_cnt  [16];
  logic [3:0]  plist_src [16];
  logic        plist_rel [16];
  int          plen = 0;
  int          pcur = 0;
  logic [3:0]  taken = '0;
  logic        drained = 1'b0;
  logic [3:0]  rank_q = '0;
  logic [15:0] absent_q = '0;

  beat_t   request_q[$];
  result_t due_replies[$];
  int      n_queued = 0;
  int      n_replies = 0;
  int      n_bad = 0;
  int      send_idle_pct = 0;
  int      take_stall_pct = 0;
  result_t seen_r;
  result_t want_r;

  initial begin
    for (int i = 0; i < 16; i++) begin
      arr_sig[i] = '0;
      disp_cnt[i] = '0;
      plist_src[i] = '0;
      plist_rel[i] = 1'b0;
    end
  end

  function automatic void rebuild_pending();
    logic held [16];
    int   k;
    int   fin;
    k = 0;
    fin = 0;
    for (int i = 0; i < 16; i++) held[i] = 1'b0;
    for (int i = 0; i < plen; i++) begin
      if (!plist_rel[i] && !held[plist_src[i]]) begin
        held[plist_src[i]] = 1'b1;
        plist_src[k] = plist_src[i];
        plist_rel[k] = 1'b0;
        k++;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (!held[i]) begin
        if (arr_sig[i][32:1] > disp_cnt[i]) begin
          if (k < 16) begin
            plist_src[k] = 4'(i);
            plist_rel[k] = 1'b0;
            k++;
          end
        end else begin
          fin += int'(arr_sig[i][0]);
        end
      end
    end
    drained = (fin == 16);
    plen = k;
    pcur = 0;
  endfunction

  function automatic result_t track_credit(beat_t b);
    result_t     res;
    logic [31:0] old;
    res = '0;
    case (b.mode)
      MODE_ARRIVE: arr_sig[b.source] = b.signal_value;
      MODE_BORROW: begin
        if (pcur == plen) rebuild_pending();
        if (pcur < plen) begin
          taken = plist_src[pcur];
          res.got_buffer = 1'b1;
          res.buffer_source = taken;
          res.buffer_level = disp_cnt[taken][1:0];
        end
        res.all_drained = drained;
      end
      MODE_RETURN: begin
        if (pcur < plen) begin
          if (b.buffer_done) begin
            old = disp_cnt[taken];
            plist_rel[pcur] = 1'b1;
            disp_cnt[taken] = old + 32'd1;
            res.ack_valid = 1'b1;
            res.ack_source = taken;
            res.ack_slot = {rank_q, old[1:0]};
            res.ack_value = 33'(old >> 2) + 33'd1;
          end
          pcur++;
        end
      end
      MODE_RESTART: begin
        for (int i = 0; i < 16; i++) begin
          disp_cnt[i] = '0;
          arr_sig[i] = {32'd0, absent_q[i]};
        end
        plen = 0;
        pcur = 0;
        taken = '0;
      end
    endcase
    return res;
  endfunction

  function automatic string reply_text(result_t r);
    return $sformatf("got=%0d src=%0d lvl=%0d drn=%0d ack=%0d asrc=%0d slot=%0d val=%0h",
                     r.got_buffer, r.buffer_source, r.buffer_level, r.all_drained,
                     r.ack_valid, r.ack_source, r.ack_slot, r.ack_value);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) due_replies.push_back(track_credit(drv_beat));
      if (!drv_valid || in_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_beat <= request_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      take_q <= 1'b0;
    end else begin
      if (out_ch.valid && take_q) begin
        seen_r = '{out_ch.got_buffer, out_ch.buffer_source, out_ch.buffer_level,
                   out_ch.all_drained, out_ch.ack_valid, out_ch.ack_source,
                   out_ch.ack_slot, out_ch.ack_value};
        if (due_replies.size() == 0) begin
          if (n_bad < 10) $display("%0t: unexpected beat %s", $realtime, reply_text(seen_r));
          n_bad++;
        end else begin
          want_r = due_replies.pop_front();
          if (seen_r.got_buffer !== want_r.got_buffer ||
              seen_r.buffer_source !== want_r.buffer_source ||
              seen_r.buffer_level !== want_r.buffer_level ||
              seen_r.all_drained !== want_r.all_drained ||
              seen_r.ack_valid !== want_r.ack_valid ||
              seen_r.ack_source !== want_r.ack_source ||
              seen_r.ack_slot !== want_r.ack_slot ||
              seen_r.ack_value !== want_r.ack_value) begin
            if (n_bad < 10)
              $display("%0t: reply %0d expected %s actual %s", $realtime, n_replies,
                       reply_text(want_r), reply_text(seen_r));
            n_bad++;
          end
        end
        n_replies <= n_replies + 1;
      end
      take_q <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  task automatic push_beat(input mode_t m, input logic [3:0] s, input logic [32:0] v,
                           input logic d);
    request_q.push_back('{m, s, v, d});
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_replies != n_queued) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] rank, input logic [15:0] mask);
    cfg_we_q <= 1'b1;
    cfg_idx_q <= REG_OWN_RANK;
    cfg_data_q <= CFG_DATA_W'(rank);
    @(posedge clk);
    cfg_idx_q <= REG_ABSENT_MASK;
    cfg_data_q <= mask;
    @(posedge clk);
    cfg_we_q <= 1'b0;
    rank_q = rank;
    absent_q = mask;
  endtask

  task automatic queue_random(input int count);
    int          made;
    int          pick;
    logic [32:0] noise;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      noise = {1'($urandom_range(1)), 32'($urandom)};
      if (pick < 28) begin
        push_beat(MODE_ARRIVE, 4'($urandom_range(15)),
                  {32'($urandom_range(9)), 1'($urandom_range(1))}, 1'($urandom_range(1)));
        made++;
      end else if (pick < 62) begin
        push_beat(MODE_BORROW, 4'($urandom_range(15)), noise, 1'($urandom_range(1)));
        push_beat(MODE_RETURN, 4'($urandom_range(15)), noise, ($urandom_range(99) < 85));
        made += 2;
      end else if (pick < 72) begin
        push_beat(MODE_BORROW, 4'($urandom_range(15)), noise, 1'($urandom_range(1)));
        made++;
      end else if (pick < 86) begin
        push_beat(MODE_RETURN, 4'($urandom_range(15)), noise, 1'($urandom_range(1)));
        made++;
      end else if (pick < 89) begin
        push_beat(MODE_RESTART, 4'($urandom_range(15)), noise, 1'($urandom_range(1)));
        made++;
      end else begin
        push_beat(MODE_ARRIVE, 4'($urandom_range(15)), noise, 1'($urandom_range(1)));
        made++;
      end
    end
  endtask

  initial begin
    int          idle_tab  [4];
    int          stall_tab [4];
    logic [3:0]  rank_tab  [4];
    logic [15:0] mask_tab  [4];
    idle_tab  = '{0, 62, 0, 14};
    stall_tab = '{0, 0, 62, 14};
    rank_tab  = '{4'd0, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'd15};
    mask_tab  = '{16'h0000, 16'($urandom), 16'h7FFE, 16'($urandom)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    program_regs(4'd15, 16'hFFFF);

    // empty list, stray return, extreme signals, hold and release, restart, drain
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b1);
    push_beat(MODE_ARRIVE,  4'd0,  33'd4, 1'b0);
    push_beat(MODE_ARRIVE,  4'd15, 33'h1_FFFF_FFFF, 1'b1);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b1);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b1);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b1);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RESTART, 4'd15, 33'h1_FFFF_FFFF, 1'b1);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_ARRIVE,  4'd3,  33'd0, 1'b0);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_ARRIVE,  4'd3,  33'd1, 1'b0);
    push_beat(MODE_BORROW,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_ARRIVE,  4'd7,  33'h0_AAAA_5555, 1'b1);
    push_beat(MODE_RETURN,  4'd0,  33'd0, 1'b0);
    push_beat(MODE_RESTART, 4'd0,  33'd0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      program_regs(rank_tab[ph], mask_tab[ph]);
      send_idle_pct = idle_tab[ph];
      take_stall_pct = stall_tab[ph];
      push_beat(MODE_RESTART, 4'd0, 33'd0, 1'b0);
      queue_random(68);
      // hold the sender until every reply is back
      wait_drained();
      queue_random(69);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (n_bad == 0 && due_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rbct_pkg.sv
sv/rbct_in_if.sv
sv/rbct_out_if.sv
sv/rbct_store.sv
sv/rbct_alu.sv
sv/rbct_ctrl.sv
sv/receive_buffer_credit_tracker_unit.sv
sim/receive_buffer_credit_tracker_unit_tb.sv
